@@ hdl/polarized_cross_power_spectrum_macros.svh @@
// ----------------------------------------------------------------------------
// polarized_cross_power_spectrum_macros
// Assertion helpers shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef POLARIZED_CROSS_POWER_SPECTRUM_MACROS_SVH
`define POLARIZED_CROSS_POWER_SPECTRUM_MACROS_SVH

// Same-cycle implication, cleared during reset
`define PCPS_ASSERT_NOW(lbl, ant, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (con)) \
		else $error(msg);

// Next-cycle implication, cleared during reset
`define PCPS_ASSERT_NEXT(lbl, ant, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (con)) \
		else $error(msg);

`endif

@@ hdl/pcps_pkg.sv @@
// ----------------------------------------------------------------------------
// pcps_pkg
// Shared constants, lane control type and lane pairing tables.
// ----------------------------------------------------------------------------
package pcps_pkg;

	localparam int COEF_IN_W    = 24;
	localparam int COEF_W       = 24;
	localparam int PROD_W       = 2 * COEF_W;
	localparam int SUM_W        = 64;
	localparam int DEG_W        = 12;
	localparam int DIVS_W       = DEG_W + 1;
	localparam int DEGREE_LIMIT = 4095;
	localparam int LANES        = 6;
	localparam int NUM_COEF     = 12;
	localparam int DIV_STEPS    = SUM_W;
	localparam int CNT_W        = $clog2(DIV_STEPS);
	localparam int IN_TDATA_W   = NUM_COEF * COEF_IN_W;
	localparam int OUT_BITS     = DEG_W + LANES * SUM_W;
	localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;
	localparam int CFG_IDX_W    = 2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DEGREE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ORDER  = 2'd1;

	// Coefficient slot of each lane's first-set and second-set operand
	// (TT, GG, CC, TG, TC, GC); the imaginary part sits one slot above.
	localparam int LANE_A [LANES] = '{0, 2, 4, 0, 0, 2};
	localparam int LANE_B [LANES] = '{6, 8, 10, 8, 10, 10};

	typedef struct packed {
		logic mul;
		logic acc;
		logic first;
		logic div_start;
		logic div_step;
	} lane_ctrl_t;

endpackage

@@ hdl/polarized_cross_power_spectrum.sv @@
// ----------------------------------------------------------------------------
// polarized_cross_power_spectrum
// Cross angular power spectra of two T/G/C coefficient sets, per degree.
// ----------------------------------------------------------------------------
// One request per coefficient order, degree-major, orders 0..min(l, max_order).
// Six lanes (TT, GG, CC, TG, TC, GC) multiply and accumulate side by side.
// An order that does not close a degree has a product and an accumulate step.
// The last order of a degree then runs ST_DSTART, ST_DIV and ST_DONE: sums are
// divided by 2l+1 in each lane's bit-serial divider, one quotient bit a cycle,
// and the result then waits in the output register if the sink stalls. A new
// request is taken while that result waits; the next result waits in ST_DONE
// until the output register is free. No clearing pass after reset.
module polarized_cross_power_spectrum (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// config write
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [pcps_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pcps_pkg::DEG_W-1:0]           cfg_data,
	// fields from bit 0 up, 24 bits each: first_t_re, first_t_im, first_g_re,
	// first_g_im, first_c_re, first_c_im, second_t_re, second_t_im,
	// second_g_re, second_g_im, second_c_re, second_c_im
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [pcps_pkg::IN_TDATA_W-1:0]      s_tdata,
	// fields from bit 0 up: degree_out (12), power_tt, power_gg, power_cc,
	// power_tg, power_tc, power_gc (64 each), zero padding (4)
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [pcps_pkg::OUT_TDATA_W-1:0]     m_tdata
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_ACC    = 5'b00010,
		ST_DSTART = 5'b00100,
		ST_DIV    = 5'b01000,
		ST_DONE   = 5'b10000
	} state_t;

	state_t                          state_q;
	logic [pcps_pkg::DEG_W-1:0]      max_degree_q, max_order_q;
	logic [pcps_pkg::DEG_W-1:0]      cur_degree_q, cur_order_q, limit, lmax;
	logic [pcps_pkg::DEG_W-1:0]      deg_out_q;
	logic [pcps_pkg::DIVS_W-1:0]     divisor_q;
	logic [pcps_pkg::CNT_W-1:0]      cnt_q;
	logic                            first_q, accept, out_free;
	pcps_pkg::lane_ctrl_t            ctrl;
	logic [pcps_pkg::COEF_IN_W-1:0]  coef [pcps_pkg::NUM_COEF];
	logic [pcps_pkg::SUM_W-1:0]      quot [pcps_pkg::LANES];
	logic                            m_tvalid_q;
	logic [pcps_pkg::OUT_TDATA_W-1:0] m_tdata_q;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	// Config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_degree_q <= '0;
			max_order_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				pcps_pkg::REG_MAX_DEGREE: max_degree_q <= cfg_data;
				pcps_pkg::REG_MAX_ORDER:  max_order_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign limit = (cur_degree_q < max_order_q) ? cur_degree_q : max_order_q;
	assign lmax  = (max_degree_q < pcps_pkg::DEG_W'(pcps_pkg::DEGREE_LIMIT))
		? max_degree_q : pcps_pkg::DEG_W'(pcps_pkg::DEGREE_LIMIT);

	// Lane controls
	always_comb begin
		ctrl.mul       = accept;
		ctrl.acc       = (state_q == ST_ACC);
		ctrl.first     = first_q;
		ctrl.div_start = (state_q == ST_DSTART);
		ctrl.div_step  = (state_q == ST_DIV);
	end

	// Sequencer, degree and order counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cur_degree_q <= '0;
			cur_order_q  <= '0;
			first_q      <= 1'b0;
			cnt_q        <= '0;
			m_tvalid_q   <= 1'b0;
		end else begin
			// new result loads, otherwise a taken result clears
			if (state_q == ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						first_q <= (cur_order_q == '0);
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					if (cur_order_q < limit) begin
						cur_order_q <= cur_order_q + 1'b1;
						state_q     <= ST_IDLE;
					end else begin
						cur_order_q  <= '0;
						cur_degree_q <= (cur_degree_q >= lmax) ? '0 : cur_degree_q + 1'b1;
						state_q      <= ST_DSTART;
					end
				end
				ST_DSTART: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == pcps_pkg::CNT_W'(pcps_pkg::DIV_STEPS - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Degree being closed and its divisor 2l+1
	always_ff @(posedge clk) begin
		if (state_q == ST_ACC) begin
			deg_out_q <= cur_degree_q;
			divisor_q <= {cur_degree_q, 1'b1};
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			m_tdata_q <= {{(pcps_pkg::OUT_TDATA_W - pcps_pkg::OUT_BITS){1'b0}},
				quot[5], quot[4], quot[3], quot[2], quot[1], quot[0], deg_out_q};
		end
	end

	// Unpack coefficients
	for (genvar i = 0; i < pcps_pkg::NUM_COEF; i++) begin : g_coef
		assign coef[i] = s_tdata[i*pcps_pkg::COEF_IN_W +: pcps_pkg::COEF_IN_W];
	end

	// Spectrum lanes
	for (genvar k = 0; k < pcps_pkg::LANES; k++) begin : g_lane
		pcps_lane u_lane (
			.clk     (clk),
			.ctrl    (ctrl),
			.divisor (divisor_q),
			.a_re    (coef[pcps_pkg::LANE_A[k]]),
			.a_im    (coef[pcps_pkg::LANE_A[k] + 1]),
			.b_re    (coef[pcps_pkg::LANE_B[k]]),
			.b_im    (coef[pcps_pkg::LANE_B[k] + 1]),
			.quot    (quot[k])
		);
	end

endmodule

@@ hdl/pcps_lane.sv @@
// ----------------------------------------------------------------------------
// pcps_lane
// One spectrum lane: complex dot product, accumulator and bit-serial divider.
// ----------------------------------------------------------------------------
module pcps_lane (
	input  logic                                clk,
	input  pcps_pkg::lane_ctrl_t                ctrl,
	input  logic [pcps_pkg::DIVS_W-1:0]         divisor,
	input  logic [pcps_pkg::COEF_IN_W-1:0]      a_re,
	input  logic [pcps_pkg::COEF_IN_W-1:0]      a_im,
	input  logic [pcps_pkg::COEF_IN_W-1:0]      b_re,
	input  logic [pcps_pkg::COEF_IN_W-1:0]      b_im,
	output logic signed [pcps_pkg::SUM_W-1:0]   quot
);

	logic signed [pcps_pkg::COEF_W-1:0] ar, ai, br, bi;
	logic signed [pcps_pkg::PROD_W-1:0] prod_re_s1, prod_im_s1;
	logic signed [pcps_pkg::SUM_W-1:0]  re_ext, im_ext, term, sum_q;
	logic [pcps_pkg::SUM_W-1:0]         mag_q;
	logic [pcps_pkg::DIVS_W-1:0]        rem_q;
	logic [pcps_pkg::DIVS_W:0]          shifted, trial;
	logic                               neg_q;

	// Low COEF_W bits, sign taken from their top bit
	assign ar = a_re[pcps_pkg::COEF_W-1:0];
	assign ai = a_im[pcps_pkg::COEF_W-1:0];
	assign br = b_re[pcps_pkg::COEF_W-1:0];
	assign bi = b_im[pcps_pkg::COEF_W-1:0];

	// Product registers
	always_ff @(posedge clk) begin
		if (ctrl.mul) begin
			prod_re_s1 <= ar * br;
			prod_im_s1 <= ai * bi;
		end
	end

	// Order zero: real part only; otherwise twice the real dot product
	assign re_ext = pcps_pkg::SUM_W'(prod_re_s1);
	assign im_ext = pcps_pkg::SUM_W'(prod_im_s1);
	assign term   = ctrl.first ? re_ext : ((re_ext + im_ext) <<< 1);

	always_ff @(posedge clk) begin
		if (ctrl.acc) begin
			sum_q <= ctrl.first ? term : sum_q + term;
		end
	end

	// Restoring division of the magnitude, one quotient bit a cycle
	assign shifted = {rem_q, mag_q[pcps_pkg::SUM_W-1]};
	assign trial   = shifted - {1'b0, divisor};

	always_ff @(posedge clk) begin
		if (ctrl.div_start) begin
			neg_q <= sum_q[pcps_pkg::SUM_W-1];
			mag_q <= sum_q[pcps_pkg::SUM_W-1] ? -sum_q : sum_q;
			rem_q <= '0;
		end else if (ctrl.div_step) begin
			if (!trial[pcps_pkg::DIVS_W]) begin
				rem_q <= trial[pcps_pkg::DIVS_W-1:0];
				mag_q <= {mag_q[pcps_pkg::SUM_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[pcps_pkg::DIVS_W-1:0];
				mag_q <= {mag_q[pcps_pkg::SUM_W-2:0], 1'b0};
			end
		end
	end

	// Truncation toward zero: restore the sign
	assign quot = neg_q ? -mag_q : mag_q;

endmodule

@@ hdl/pcps_checker.sv @@
// ----------------------------------------------------------------------------
// pcps_checker
// Port-level checks on the spectrum block, bound to the top level.
// ----------------------------------------------------------------------------
`include "polarized_cross_power_spectrum_macros.svh"

module pcps_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [pcps_pkg::OUT_TDATA_W-1:0]  m_tdata
);

	// Stalled result stays
	`PCPS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
	`PCPS_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata), "result changed while stalled")
	// One request in work at a time
	`PCPS_ASSERT_NEXT(a_one_req, s_tvalid && s_tready, !s_tready, "request taken while busy")
	// An offered result carries known data
	`PCPS_ASSERT_NOW(a_out_known, m_tvalid, !$isunknown(m_tdata), "result data unknown")

endmodule

bind polarized_cross_power_spectrum pcps_checker u_pcps_checker (.*);

@@ verif/polarized_cross_power_spectrum_checker.sv @@
// ----------------------------------------------------------------------------
// polarized_cross_power_spectrum_checker
// Watches the config, coefficient and spectrum channels, predicts each degree's
// six spectra from the accepted coefficient requests and compares results.
// ----------------------------------------------------------------------------
module polarized_cross_power_spectrum_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	input  logic                                 cfg_ready,
	input  logic [pcps_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pcps_pkg::DEG_W-1:0]           cfg_data,
	input  logic                                 s_tvalid,
	input  logic                                 s_tready,
	input  logic [pcps_pkg::IN_TDATA_W-1:0]      s_tdata,
	input  logic                                 m_tvalid,
	input  logic                                 m_tready,
	input  logic [pcps_pkg::OUT_TDATA_W-1:0]     m_tdata,
	output int                                   errors,
	output int                                   pending,
	output int                                   spectra_seen
);
	import pcps_pkg::*;

	typedef struct packed {
		logic [DEG_W-1:0]           degree;
		logic [LANES-1:0][SUM_W-1:0] power;
	} spectrum_t;

	spectrum_t spectrum_queue [$];

	// model state
	logic [DEG_W-1:0] max_degree_q, max_order_q;
	logic [DEG_W-1:0] degree_q, order_q;
	logic [LANES-1:0][SUM_W-1:0] sums_q;

	assign pending = spectrum_queue.size();

	// one lane's contribution of the current order
	function automatic logic [SUM_W-1:0] lane_term(longint ar, longint ai, longint br,
		longint bi, logic first);
		longint re_p;
		longint im_p;
		re_p = ar * br;
		im_p = ai * bi;
		if (first)
			return re_p;
		return 2 * (re_p + im_p);
	endfunction

	// accumulate one coefficient request; push a spectrum when a degree closes
	task automatic predict_spectrum(input logic [IN_TDATA_W-1:0] data);
		longint c [NUM_COEF];
		logic first;
		logic [DEG_W-1:0] limit;
		logic [DEG_W-1:0] top_degree;
		logic [SUM_W-1:0] t;
		longint divisor;
		spectrum_t s;
		first = (order_q == 0);
		for (int i = 0; i < NUM_COEF; i++)
			c[i] = $signed(data[i*COEF_IN_W +: COEF_IN_W]);
		for (int k = 0; k < LANES; k++) begin
			t = lane_term(c[LANE_A[k]], c[LANE_A[k]+1], c[LANE_B[k]], c[LANE_B[k]+1],
				first);
			sums_q[k] = first ? t : sums_q[k] + t;
		end
		limit = (degree_q < max_order_q) ? degree_q : max_order_q;
		if (order_q < limit) begin
			order_q = order_q + 1'b1;
		end else begin
			divisor = 2 * longint'(degree_q) + 1;
			s.degree = degree_q;
			for (int k = 0; k < LANES; k++)
				s.power[k] = $signed(sums_q[k]) / divisor;
			spectrum_queue.push_back(s);
			top_degree = (max_degree_q < DEG_W'(DEGREE_LIMIT)) ? max_degree_q
				: DEG_W'(DEGREE_LIMIT);
			degree_q = (degree_q >= top_degree) ? '0 : degree_q + 1'b1;
			order_q = '0;
		end
	endtask

	// channel monitor
	always @(posedge clk or negedge arst_n) begin
		spectrum_t exp_s;
		spectrum_t got;
		if (!arst_n) begin
			max_degree_q = '0;
			max_order_q = '0;
			degree_q = '0;
			order_q = '0;
			sums_q = '0;
			errors = 0;
			spectra_seen = 0;
			spectrum_queue.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_MAX_DEGREE)
					max_degree_q = cfg_data;
				else if (cfg_index == REG_MAX_ORDER)
					max_order_q = cfg_data;
			end
			if (s_tvalid && s_tready)
				predict_spectrum(s_tdata);
			if (m_tvalid && m_tready) begin
				spectra_seen++;
				got.degree = m_tdata[DEG_W-1:0];
				for (int k = 0; k < LANES; k++)
					got.power[k] = m_tdata[DEG_W + k*SUM_W +: SUM_W];
				if (spectrum_queue.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("ERROR: unexpected spectrum, degree %0d", got.degree);
				end else begin
					exp_s = spectrum_queue.pop_front();
					if (got != exp_s) begin
						errors++;
						if (errors <= 10) begin
							$display("ERROR: degree exp %0d got %0d", exp_s.degree,
								got.degree);
							for (int k = 0; k < LANES; k++)
								if (got.power[k] != exp_s.power[k])
									$display("  lane %0d exp %h got %h", k,
										exp_s.power[k], got.power[k]);
						end
					end
				end
			end
		end
	end

endmodule

@@ verif/polarized_cross_power_spectrum_tb.sv @@
// ----------------------------------------------------------------------------
// polarized_cross_power_spectrum_tb
// Drives register settings and coefficient requests with random idling and a
// long sink stall; the checker predicts and compares every degree's spectra.
// ----------------------------------------------------------------------------
module polarized_cross_power_spectrum_tb;
	import pcps_pkg::*;

	localparam int DRAIN_CYCLES = 80;
	localparam int WATCHDOG_LIMIT = 4000;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DEG_W-1:0] cfg_data;
	logic s_tvalid;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;

	int errors, pending, spectra_seen;
	int items_sent;
	int settings_done;
	int idle_cycles = 0;
	int cycle_cnt;

	polarized_cross_power_spectrum dut (.*);

	polarized_cross_power_spectrum_checker checker_i (.*);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// pick a coefficient value, biased toward the extremes
	function automatic logic [COEF_IN_W-1:0] pick_coef();
		case ($urandom_range(0, 7))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2: return '0;
			default: return COEF_IN_W'($urandom());
		endcase
	endfunction

	function automatic logic [IN_TDATA_W-1:0] random_coefs();
		logic [IN_TDATA_W-1:0] d;
		for (int i = 0; i < NUM_COEF; i++)
			d[i*COEF_IN_W +: COEF_IN_W] = pick_coef();
		return d;
	endfunction

	function automatic logic [IN_TDATA_W-1:0] fill_coefs(logic [COEF_IN_W-1:0] v);
		logic [IN_TDATA_W-1:0] d;
		for (int i = 0; i < NUM_COEF; i++)
			d[i*COEF_IN_W +: COEF_IN_W] = v;
		return d;
	endfunction

	// one register write request
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DEG_W-1:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// new setting, only while the block is idle
	task automatic apply_setting(input logic [DEG_W-1:0] mdeg, input logic [DEG_W-1:0] mord);
		write_reg(REG_MAX_DEGREE, mdeg);
		write_reg(REG_MAX_ORDER, mord);
		settings_done++;
	endtask

	// one coefficient request, with random idling outside the quiet stretch
	task automatic send_coefs(input logic [IN_TDATA_W-1:0] d);
		int gap;
		gap = 0;
		if ((items_sent < 500 || items_sent > 700) && $urandom_range(0, 99) < 26)
			gap = $urandom_range(1, 6);
		if (gap != 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = d;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic drain();
		s_tvalid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic random_phase(input int n);
		for (int i = 0; i < n; i++)
			send_coefs(random_coefs());
		drain();
	endtask

	// sink: random stalls, a quiet stretch, and one long hold-off that starts
	// while the sender is offering into a busy block
	initial begin
		int hold;
		bit hold_done;
		m_tready = 1'b0;
		cycle_cnt = 0;
		hold = 0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			cycle_cnt++;
			if (!hold_done && items_sent >= 300 && s_tvalid && !s_tready) begin
				hold = 400;
				hold_done = 1'b1;
			end
			if (hold > 0) begin
				hold--;
				m_tready = 1'b0;
			end else if (cycle_cnt > 6000 && cycle_cnt < 8000)
				m_tready = 1'b1;
			else
				m_tready = ($urandom_range(0, 99) >= 26);
		end
	end

	// watchdog on cycles without any accepted request
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// stimulus
	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		items_sent = 0;
		settings_done = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: extreme coefficients over degrees 0..3, all orders
		apply_setting(12'd3, 12'd3);
		send_coefs(fill_coefs(24'h7FFFFF));
		send_coefs(fill_coefs(24'h800000));
		send_coefs(fill_coefs(24'h800000));
		send_coefs(fill_coefs(24'h7FFFFF));
		send_coefs(fill_coefs(24'h000000));
		send_coefs(fill_coefs(24'h000001));
		send_coefs(fill_coefs(24'hFFFFFF));
		send_coefs({6{24'h800000, 24'h7FFFFF}});
		send_coefs({6{24'h7FFFFF, 24'h800000}});
		send_coefs(fill_coefs(24'h555555));
		// degree wraps back to 0 here
		send_coefs(fill_coefs(24'hAAAAAA));
		send_coefs(fill_coefs(24'h100000));
		send_coefs({{6{24'h7FFFFF}}, {6{24'h800000}}});
		drain();
		// smaller max_order: counters sit at a degree boundary when it changes
		apply_setting(12'd5, 12'd0);
		random_phase(6);
		// extremes of both registers
		apply_setting(12'd0, 12'd0);
		random_phase(8);
		apply_setting(12'd4095, 12'd4095);
		random_phase(12);
		apply_setting(12'd4095, 12'd0);
		random_phase(10);
		apply_setting(12'd2, 12'd4095);
		random_phase(10);

		// random settings, mostly small sweeps
		while (items_sent < 1100) begin
			apply_setting(DEG_W'($urandom_range(0, 10)), DEG_W'($urandom_range(0, 12)));
			random_phase($urandom_range(20, 80));
		end

		drain();
		$display("Run covered %0d coefficient requests, %0d degree spectra, %0d settings.",
			items_sent, spectra_seen, settings_done);
		if (errors == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
